[hw/rtl/assert_macros.svh]
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, quiet during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

[hw/rtl/sconv_pkg.sv]
// Package: commands, constants and the front-to-back job type
package sconv_pkg;
   typedef enum logic [1:0] {
      CMD_WEIGHT  = 2'd0,
      CMD_BIAS    = 2'd1,
      CMD_SAMPLE  = 2'd2,
      CMD_RESTART = 2'd3
   } cmd_type;

   localparam logic [1:0] REG_IN_CH  = 2'd0;
   localparam logic [1:0] REG_OUT_CH = 2'd1;
   localparam logic [1:0] REG_TAPS   = 2'd2;
   localparam logic [1:0] REG_STRIDE = 2'd3;

   localparam int SUM_W = 40;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_BIAS,
      BK_MAC,
      BK_OUT
   } back_state_type;

   // one emit job: window head slot, position, and the counts it was taken with
   typedef struct packed {
      logic [4:0]  slot_head;
      logic [15:0] position;
      logic [4:0]  nin;
      logic [6:0]  nout;
      logic [5:0]  taps;
   } job_type;
endpackage

[hw/rtl/sconv_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read
module sconv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_ff;
endmodule

[hw/rtl/sconv_front.sv]
// Front end: decodes commands, writes stores, tracks columns, queues emit jobs
module sconv_front #(
   parameter int MAX_IN_CHANNELS  = 16,
   parameter int MAX_OUT_CHANNELS = 16,
   parameter int MAX_TAPS         = 8,
   parameter int WA = 11,
   parameter int SA = 7,
   parameter int BA = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [3:0]  req_out_channel,
   input  logic [3:0]  req_in_channel,
   input  logic [2:0]  req_tap,
   input  logic signed [15:0] req_sample_value,
   input  logic signed [31:0] req_bias_value,
   output logic        w_we,
   output logic [WA-1:0] w_addr,
   output logic [15:0] w_data,
   output logic        b_we,
   output logic [BA-1:0] b_addr,
   output logic [31:0] b_data,
   output logic        s_we,
   output logic [SA-1:0] s_addr,
   output logic [15:0] s_data,
   output logic        job_valid,
   output sconv_pkg::job_type job,
   input  logic        job_take
);
   import sconv_pkg::*;

   localparam int NI = (MAX_IN_CHANNELS  < 16) ? MAX_IN_CHANNELS  : 16;
   localparam int NO = (MAX_OUT_CHANNELS < 16) ? MAX_OUT_CHANNELS : 16;
   localparam int NT = (MAX_TAPS < 8) ? MAX_TAPS : 8;

   logic [4:0] in_ch_ff, out_ch_ff;
   logic [3:0] taps_ff;
   logic [7:0] stride_ff;
   logic [3:0] filled_ff, filled_in;
   logic [7:0] phase_ff, phase_in;
   logic [15:0] pos_ff, pos_in;
   logic [4:0] head_ff, head_in;
   logic       jv_ff, jv_in;
   job_type    job_ff, job_in;

   logic [4:0] nin, nout, ntaps;
   logic [7:0] stride;
   logic       acc, is_sample, closes, emit;
   logic [4:0] filled_next;

   always_comb begin
      nin   = (in_ch_ff == 5'd0) ? 5'd1 : (in_ch_ff > 5'(NI)) ? 5'(NI) : in_ch_ff;
      nout  = (out_ch_ff == 5'd0) ? 5'd1 : (out_ch_ff > 5'(NO)) ? 5'(NO) : out_ch_ff;
      ntaps = (taps_ff == 4'd0) ? 5'd1 :
              ({1'b0, taps_ff} > 5'(NT)) ? 5'(NT) : {1'b0, taps_ff};
      stride = (stride_ff == 8'd0) ? 8'd1 : stride_ff;
   end

   // one job in the queue slot at most; hold all requests while it is unread
   assign req_stall = jv_ff;
   assign acc = req_valid && !req_stall;
   assign is_sample = acc && (req_command == CMD_SAMPLE) && ({1'b0, req_in_channel} < nin);
   assign closes = is_sample && ({1'b0, req_in_channel} == nin - 5'd1);

   assign w_we = acc && (req_command == CMD_WEIGHT) && (32'(req_out_channel) < MAX_OUT_CHANNELS)
                 && (32'(req_in_channel) < MAX_IN_CHANNELS) && (32'(req_tap) < MAX_TAPS);
   assign w_addr = WA'((32'(req_out_channel) * MAX_IN_CHANNELS + 32'(req_in_channel))
                       * MAX_TAPS + 32'(req_tap));
   assign w_data = req_sample_value;
   assign b_we = acc && (req_command == CMD_BIAS) && (32'(req_out_channel) < MAX_OUT_CHANNELS);
   assign b_addr = BA'(req_out_channel);
   assign b_data = req_bias_value;
   // sample writes wait while the back end reads the window
   assign s_we = is_sample;
   assign s_addr = SA'(32'(head_ff) * MAX_IN_CHANNELS + 32'(req_in_channel));
   assign s_data = req_sample_value;

   always_comb begin
      filled_in = filled_ff;
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      head_in   = head_ff;
      jv_in     = jv_ff && !job_take;
      job_in    = job_ff;
      emit      = 1'b0;
      filled_next = {1'b0, filled_ff};
      if (acc && req_command == CMD_RESTART) begin
         filled_in = '0; phase_in = '0; pos_in = '0; head_in = '0;
      end else if (closes) begin
         if ({1'b0, filled_ff} < ntaps) filled_next = {1'b0, filled_ff} + 5'd1;
         filled_in = filled_next[3:0];
         if (filled_next >= ntaps) begin
            emit = (phase_ff == 8'd0);
            phase_in = (phase_ff + 8'd1 >= stride || phase_ff == 8'hFF) ? 8'd0 : phase_ff + 8'd1;
         end
         if (emit) begin
            jv_in = 1'b1;
            job_in.slot_head = head_ff;
            job_in.position  = pos_ff;
            job_in.nin  = nin;
            job_in.nout = {2'b0, nout};
            job_in.taps = {1'b0, ntaps};
            pos_in = pos_ff + 16'd1;
         end
         head_in = (32'(head_ff) + 1 >= MAX_TAPS) ? 5'd0 : head_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ch_ff <= 5'd1; out_ch_ff <= 5'd1; taps_ff <= 4'd1; stride_ff <= 8'd1;
         filled_ff <= '0; phase_ff <= '0; pos_ff <= '0; head_ff <= '0; jv_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_IN_CH:  in_ch_ff  <= csr_data[4:0];
               REG_OUT_CH: out_ch_ff <= csr_data[4:0];
               REG_TAPS:   taps_ff   <= csr_data[3:0];
               REG_STRIDE: stride_ff <= csr_data;
               default: ;
            endcase
         end
         filled_ff <= filled_in; phase_ff <= phase_in; pos_ff <= pos_in;
         head_ff <= head_in; jv_ff <= jv_in;
      end
      job_ff <= job_in;
   end

   assign job_valid = jv_ff;
   assign job = job_ff;
endmodule

[hw/rtl/sconv_back.sv]
// Back end: serial MAC over window and weights, then one result per channel
module sconv_back #(
   parameter int MAX_IN_CHANNELS  = 16,
   parameter int MAX_OUT_CHANNELS = 16,
   parameter int MAX_TAPS         = 8,
   parameter int WA = 11,
   parameter int SA = 7,
   parameter int BA = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   input  sconv_pkg::job_type job,
   output logic        job_take,
   output logic        busy,
   output logic [WA-1:0] w_raddr,
   input  logic signed [15:0] w_rdata,
   output logic [SA-1:0] s_raddr,
   input  logic signed [15:0] s_rdata,
   output logic [BA-1:0] b_raddr,
   input  logic signed [31:0] b_rdata,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_channel_index,
   output logic [15:0] rsp_position,
   output logic signed [39:0] rsp_sum_value,
   output logic        rsp_last
);
   import sconv_pkg::*;

   back_state_type st_ff, st_in;
   job_type jb_ff, jb_in;
   logic [6:0] oc_ff, oc_in;
   logic [5:0] tp_ff, tp_in;
   logic [4:0] ic_ff, ic_in;
   logic       issue_ff, issue_in;   // a read was issued last cycle
   logic       go_ff, go_in;         // read the current address this cycle
   logic       bias_ff, bias_in;
   logic signed [SUM_W-1:0] acc_ff, acc_in;
   logic       ov_ff, ov_in;
   logic [3:0] och_ff, och_in;
   logic [15:0] opos_ff, opos_in;
   logic signed [SUM_W-1:0] osum_ff, osum_in;
   logic       olast_ff, olast_in;
   logic       last_rd;
   logic [6:0] slot_sum;
   logic [5:0] slot;
   logic signed [31:0] prod;

   always_comb begin
      // ring slot of this tap: head minus its age, wrapped once
      slot_sum = 7'(32'(jb_ff.slot_head) + MAX_TAPS - (32'(jb_ff.taps) - 1 - 32'(tp_ff)));
      slot = (32'(slot_sum) >= MAX_TAPS) ? 6'(32'(slot_sum) - MAX_TAPS) : slot_sum[5:0];
      w_raddr = WA'((32'(oc_ff) * MAX_IN_CHANNELS + 32'(ic_ff)) * MAX_TAPS + 32'(tp_ff));
      s_raddr = SA'(32'(slot) * MAX_IN_CHANNELS + 32'(ic_ff));
      b_raddr = BA'(oc_ff);
      last_rd = (ic_ff == jb_ff.nin - 5'd1) && (tp_ff == jb_ff.taps - 6'd1);
      prod = s_rdata * w_rdata;
   end

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         BK_IDLE: if (job_valid) st_in = BK_BIAS;
         BK_BIAS: st_in = BK_MAC;
         BK_MAC:  if (!go_ff && !bias_ff) st_in = BK_OUT;
         BK_OUT:  if (!ov_ff || !rsp_stall)
                     st_in = (oc_ff == jb_ff.nout - 7'd1) ? BK_IDLE : BK_BIAS;
         default: st_in = BK_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      jb_in = jb_ff; oc_in = oc_ff; tp_in = tp_ff; ic_in = ic_ff;
      issue_in = 1'b0; go_in = 1'b0; bias_in = 1'b0; acc_in = acc_ff;
      ov_in = ov_ff && rsp_stall;
      och_in = och_ff; opos_in = opos_ff; osum_in = osum_ff; olast_in = olast_ff;
      job_take = 1'b0;
      case (st_ff)
         BK_IDLE: if (job_valid) begin
            jb_in = job; oc_in = '0; job_take = 1'b1;
         end
         BK_BIAS: begin
            tp_in = '0; ic_in = '0; bias_in = 1'b1; go_in = 1'b1;
         end
         BK_MAC: begin
            if (bias_ff) acc_in = SUM_W'(b_rdata);
            else if (issue_ff) acc_in = acc_ff + SUM_W'(prod);
            if (go_ff) begin
               issue_in = 1'b1;
               // advance the address until the last product has been read
               if (!last_rd) begin
                  go_in = 1'b1;
                  if (ic_ff == jb_ff.nin - 5'd1) begin ic_in = '0; tp_in = tp_ff + 6'd1; end
                  else ic_in = ic_ff + 5'd1;
               end
            end
         end
         BK_OUT: if (!ov_ff || !rsp_stall) begin
            ov_in = 1'b1; och_in = oc_ff[3:0]; opos_in = jb_ff.position;
            osum_in = acc_ff; olast_in = (oc_ff == jb_ff.nout - 7'd1);
            oc_in = oc_ff + 7'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= BK_IDLE; ov_ff <= 1'b0; issue_ff <= 1'b0; go_ff <= 1'b0; bias_ff <= 1'b0;
      end else begin
         st_ff <= st_in; ov_ff <= ov_in; issue_ff <= issue_in; go_ff <= go_in;
         bias_ff <= bias_in;
      end
      jb_ff <= jb_in; oc_ff <= oc_in; tp_ff <= tp_in; ic_ff <= ic_in; acc_ff <= acc_in;
      och_ff <= och_in; opos_ff <= opos_in; osum_ff <= osum_in; olast_ff <= olast_in;
   end

   assign busy = (st_ff != BK_IDLE);
   assign rsp_valid = ov_ff;
   assign rsp_channel_index = och_ff;
   assign rsp_position = opos_ff;
   assign rsp_sum_value = osum_ff;
   assign rsp_last = olast_ff;
endmodule

[hw/rtl/strided_conv1d_multichannel_core.sv]
// Top level: strided multichannel 1-D convolution core
// Throughput: one item per cycle while the back end is idle; every item is held while a
// job waits or runs, and a position is worked out channel by channel in the single MAC.
// A result stalled at the output holds the back end in its output state.
// Reset (synchronous, active high) clears counters, handshakes; CSRs go to 1, stores stay.
module strided_conv1d_multichannel_core #(
   parameter int MAX_IN_CHANNELS  = 16,
   parameter int MAX_OUT_CHANNELS = 16,
   parameter int MAX_TAPS         = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [3:0]  req_out_channel,
   input  logic [3:0]  req_in_channel,
   input  logic [2:0]  req_tap,
   input  logic signed [15:0] req_sample_value,
   input  logic signed [31:0] req_bias_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_channel_index,
   output logic [15:0] rsp_position,
   output logic signed [39:0] rsp_sum_value,
   output logic        rsp_last
);
   import sconv_pkg::*;

   localparam int WD = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_TAPS;
   localparam int SD = MAX_TAPS * MAX_IN_CHANNELS;
   localparam int BD = MAX_OUT_CHANNELS;
   localparam int WA = (WD > 1) ? $clog2(WD) : 1;
   localparam int SA = (SD > 1) ? $clog2(SD) : 1;
   localparam int BA = (BD > 1) ? $clog2(BD) : 1;

   logic w_we, b_we, s_we, job_valid, job_take, busy, f_stall;
   logic [WA-1:0] w_addr, w_raddr;
   logic [SA-1:0] s_addr, s_raddr;
   logic [BA-1:0] b_addr, b_raddr;
   logic [15:0] w_data, s_data, w_rdata, s_rdata;
   logic [31:0] b_data, b_rdata;
   job_type job;

   // hold all items while the back end works so the window stays put
   assign req_stall = f_stall || busy;

   sconv_front #(.MAX_IN_CHANNELS(MAX_IN_CHANNELS), .MAX_OUT_CHANNELS(MAX_OUT_CHANNELS),
      .MAX_TAPS(MAX_TAPS), .WA(WA), .SA(SA), .BA(BA)) u_front (
      .clock, .reset, .csr_write, .csr_index, .csr_data,
      .req_valid(req_valid && !busy), .req_stall(f_stall),
      .req_command, .req_out_channel, .req_in_channel, .req_tap,
      .req_sample_value, .req_bias_value,
      .w_we, .w_addr, .w_data, .b_we, .b_addr, .b_data, .s_we, .s_addr, .s_data,
      .job_valid, .job, .job_take);

   sconv_back #(.MAX_IN_CHANNELS(MAX_IN_CHANNELS), .MAX_OUT_CHANNELS(MAX_OUT_CHANNELS),
      .MAX_TAPS(MAX_TAPS), .WA(WA), .SA(SA), .BA(BA)) u_back (
      .clock, .reset, .job_valid, .job, .job_take, .busy,
      .w_raddr, .w_rdata, .s_raddr, .s_rdata, .b_raddr, .b_rdata,
      .rsp_valid, .rsp_stall, .rsp_channel_index, .rsp_position, .rsp_sum_value, .rsp_last);

   sconv_ram #(.WIDTH(16), .DEPTH(WD)) u_wram (.clock, .wr_en(w_we), .wr_addr(w_addr),
      .wr_data(w_data), .rd_addr(w_raddr), .rd_data(w_rdata));
   sconv_ram #(.WIDTH(16), .DEPTH(SD)) u_sram (.clock, .wr_en(s_we), .wr_addr(s_addr),
      .wr_data(s_data), .rd_addr(s_raddr), .rd_data(s_rdata));
   sconv_ram #(.WIDTH(32), .DEPTH(BD)) u_bram (.clock, .wr_en(b_we), .wr_addr(b_addr),
      .wr_data(b_data), .rd_addr(b_raddr), .rd_data(b_rdata));
endmodule

[hw/rtl/sconv_checker.sv]
// Port-level checker for the convolution core, with its bind
`include "assert_macros.svh"
module sconv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_position,
   input logic        rsp_last
);
   `ASSERT_NEXT(rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_position))
   `ASSERT_NEXT(rsp_reset_clear, clock, 1'b0, reset, !rsp_valid)
   `ASSERT_IMPLY(stall_known, clock, reset, req_valid, !$isunknown(req_stall))
   `ASSERT_NEXT(pos_steady, clock, reset, rsp_valid && !rsp_stall && !rsp_last,
      !rsp_valid || rsp_position == $past(rsp_position))
endmodule

bind strided_conv1d_multichannel_core sconv_checker u_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_position, .rsp_last);
